>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the glyph pixel generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TGPG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define TGPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tgpg_pkg.sv
// Package of the glyph pixel generator: codes, glyph geometry, font table, shared types.
package tgpg_pkg;

   // Character codes
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_FIRST   = 8'd32;
   localparam logic [7:0] CODE_LAST    = 8'd127;

   // Glyph geometry
   localparam int GLYPH_W      = 6;
   localparam int GLYPH_H      = 8;
   localparam int GLYPH_PIXELS = GLYPH_W * GLYPH_H;
   localparam int GLYPH_BITS_W = GLYPH_PIXELS;
   localparam int PIX_CNT_W    = $clog2(GLYPH_PIXELS);

   // Odd panel rows sit in the upper half of the interleaved row space
   localparam logic [7:0] ODD_ROW_BASE = 8'd32;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_TEXT_COLOR = 2'd0;
   localparam logic [1:0] CSR_BACK_COLOR = 2'd1;
   localparam logic [1:0] CSR_LEFT_MARGIN = 2'd2;
   localparam logic [1:0] CSR_TOP_MARGIN = 2'd3;

   // Glyph start request from the cursor logic to the pixel sequencer
   typedef struct packed {
      logic       draw;
      logic [6:0] glyph_idx;
      logic [6:0] base_col;
      logic [6:0] base_row;
   } start_type;

   // Font lookup: column c of the glyph in byte c, top pixel in the low bit
   function automatic logic [GLYPH_BITS_W-1:0] glyph_bits(input logic [6:0] idx);
      logic [GLYPH_BITS_W-1:0] bits;
      begin
         case (idx)
            7'd0:  bits = 48'h000000000000;  7'd1:  bits = 48'h0000005F0000;
            7'd2:  bits = 48'h000003040304;  7'd3:  bits = 48'h000A3F147E28;
            7'd4:  bits = 48'h00122A7F2A24;  7'd5:  bits = 48'h006264081323;
            7'd6:  bits = 48'h005026594E30;  7'd7:  bits = 48'h000001020000;
            7'd8:  bits = 48'h0041221C0000;  7'd9:  bits = 48'h0000001C2241;
            7'd10: bits = 48'h002214081422;  7'd11: bits = 48'h0008083E0808;
            7'd12: bits = 48'h000000003050;  7'd13: bits = 48'h000808080808;
            7'd14: bits = 48'h000000006060;  7'd15: bits = 48'h000204081020;
            7'd16: bits = 48'h003E4549513E;  7'd17: bits = 48'h0000407F4200;
            7'd18: bits = 48'h004649495162;  7'd19: bits = 48'h003649494122;
            7'd20: bits = 48'h00107F121418;  7'd21: bits = 48'h00394545452F;
            7'd22: bits = 48'h00324949493E;  7'd23: bits = 48'h000305196101;
            7'd24: bits = 48'h003649494936;  7'd25: bits = 48'h003E49494926;
            7'd26: bits = 48'h000000363600;  7'd27: bits = 48'h000000365600;
            7'd28: bits = 48'h004122140800;  7'd29: bits = 48'h001414141414;
            7'd30: bits = 48'h000008142241;  7'd31: bits = 48'h000609590102;
            7'd32: bits = 48'h002E555D413E;  7'd33: bits = 48'h00601C131C60;
            7'd34: bits = 48'h00364949497F;  7'd35: bits = 48'h00224141413E;
            7'd36: bits = 48'h001C2241417F;  7'd37: bits = 48'h00414949497F;
            7'd38: bits = 48'h00010909097F;  7'd39: bits = 48'h003A4941221C;
            7'd40: bits = 48'h007F0808087F;  7'd41: bits = 48'h0000417F4100;
            7'd42: bits = 48'h003F40404020;  7'd43: bits = 48'h00412214087F;
            7'd44: bits = 48'h00004040407F;  7'd45: bits = 48'h007F0418047F;
            7'd46: bits = 48'h007F1008047F;  7'd47: bits = 48'h003E4141413E;
            7'd48: bits = 48'h00060909097F;  7'd49: bits = 48'h005E2151413E;
            7'd50: bits = 48'h00462919097F;  7'd51: bits = 48'h003249494926;
            7'd52: bits = 48'h0001017F0101;  7'd53: bits = 48'h003F4040403F;
            7'd54: bits = 48'h00031C601C03;  7'd55: bits = 48'h000F700F700F;
            7'd56: bits = 48'h004136083641;  7'd57: bits = 48'h000102780601;
            7'd58: bits = 48'h004345495161;  7'd59: bits = 48'h0041417F0000;
            7'd60: bits = 48'h0011167C1615;  7'd61: bits = 48'h0000007F4141;
            7'd62: bits = 48'h000002010200;  7'd63: bits = 48'h004040404040;
            7'd64: bits = 48'h000000020100;  7'd65: bits = 48'h007854542000;
            7'd66: bits = 48'h003844447F00;  7'd67: bits = 48'h002844443800;
            7'd68: bits = 48'h007F44443800;  7'd69: bits = 48'h001854543800;
            7'd70: bits = 48'h0001053E0400;  7'd71: bits = 48'h003C54540800;
            7'd72: bits = 48'h007804047F00;  7'd73: bits = 48'h0000007D0000;
            7'd74: bits = 48'h00003D404000;  7'd75: bits = 48'h004428107F00;
            7'd76: bits = 48'h0000007F0100;  7'd77: bits = 48'h0078047C047C;
            7'd78: bits = 48'h007804047C00;  7'd79: bits = 48'h003844443800;
            7'd80: bits = 48'h000814147C00;  7'd81: bits = 48'h007C14140800;
            7'd82: bits = 48'h000404087C00;  7'd83: bits = 48'h002454544800;
            7'd84: bits = 48'h0040443E0400;  7'd85: bits = 48'h007C40403C00;
            7'd86: bits = 48'h000C10207C00;  7'd87: bits = 48'h001C601C601C;
            7'd88: bits = 48'h006C10106C00;  7'd89: bits = 48'h001C30504C00;
            7'd90: bits = 48'h004C54644400;  7'd91: bits = 48'h004141360800;
            7'd92: bits = 48'h0000007F0000;  7'd93: bits = 48'h000008364141;
            7'd94: bits = 48'h000810080408;
            default: bits = '0;
         endcase
         return bits;
      end
   endfunction

endpackage

>>> hdl/tgpg_if.sv
// Valid/ready channel interfaces for character items and pixel items.
interface tgpg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface tgpg_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  pixel_row;
   logic [6:0]  pixel_col;
   logic [15:0] pixel_color;
   logic        off_screen;
   logic        last;

   modport source (output valid, output pixel_row, output pixel_col, output pixel_color,
                   output off_screen, output last, input ready);
   modport sink (input valid, input pixel_row, input pixel_col, input pixel_color,
                 input off_screen, input last, output ready);
endinterface

>>> hdl/tgpg_cursor.sv
// Text cursor: newline and wrap handling, glyph origin for each accepted item.
module tgpg_cursor
   import tgpg_pkg::*;
#(
   parameter int SCREEN_COLS = 96,
   parameter int SCREEN_ROWS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic [6:0] left_margin,
   input  logic [5:0] top_margin,
   output start_type  start
);

   logic [6:0] cursor_col_ff, cursor_col_in;
   logic [6:0] cursor_row_ff, cursor_row_in;
   logic       wrap;
   logic       drawable;
   logic [6:0] base_col;
   logic [7:0] row_adv;
   logic [6:0] base_row;

   // Resolve newline, right-edge wrap and bottom-edge wrap
   always_comb begin
      wrap     = (char_code == CODE_NEWLINE) || ({1'b0, cursor_col_ff} > 8'(SCREEN_COLS - 1));
      drawable = (char_code >= CODE_FIRST) && (char_code <= CODE_LAST);
      base_col = wrap ? left_margin : cursor_col_ff;
      row_adv  = {1'b0, cursor_row_ff} + (wrap ? 8'(GLYPH_H) : 8'd0);
      base_row = (row_adv > 8'(SCREEN_ROWS - 1)) ? {1'b0, top_margin} : row_adv[6:0];

      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (accept) begin
         cursor_row_in = base_row;
         cursor_col_in = drawable ? base_col + 7'(GLYPH_W) : base_col;
      end

      start.draw      = accept && drawable;
      start.glyph_idx = 7'(char_code - CODE_FIRST);
      start.base_col  = base_col;
      start.base_row  = base_row;
   end

   // Hold the cursor between items
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

>>> hdl/tgpg_pixel_seq.sv
// Pixel sequencer: steps one pixel counter through the glyph, one pixel item per cycle unless rsp stalls.
module tgpg_pixel_seq
   import tgpg_pkg::*;
#(
   parameter int SCREEN_COLS = 96,
   parameter int SCREEN_ROWS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  start_type    start,
   input  logic [15:0]  text_color,
   input  logic [15:0]  background_color,
   output logic         idle,
   tgpg_rsp_if.source   rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [PIX_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [6:0]              idx_ff;
   logic [6:0]              base_col_ff;
   logic [6:0]              base_row_ff;
   logic [GLYPH_BITS_W-1:0] glyph_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [6:0]              out_row_ff;
   logic [6:0]              out_col_ff;
   logic [15:0]             out_color_ff;
   logic                    out_off_ff;
   logic                    out_last_ff;

   logic                    load;
   logic                    pix_last;
   logic [7:0]              pix_x;
   logic [7:0]              pix_y;
   logic [7:0]              half_y;
   logic [6:0]              pix_row;
   logic                    pix_off;

   // Pixel address: glyph column from the upper counter bits, glyph row from the lower
   always_comb begin
      pix_x    = {1'b0, base_col_ff} + {5'd0, cnt_ff[PIX_CNT_W-1:3]};
      pix_y    = {1'b0, base_row_ff} + {5'd0, cnt_ff[2:0]};
      half_y   = pix_y >> 1;
      pix_row  = pix_y[0] ? 7'(ODD_ROW_BASE + half_y) : half_y[6:0];
      pix_off  = (pix_x > 8'(SCREEN_COLS - 1)) || (pix_y > 8'(SCREEN_ROWS - 1));
      pix_last = (cnt_ff == PIX_CNT_W'(GLYPH_PIXELS - 1));
      load     = (state_ff == ST_EMIT) && (!out_valid_ff || rsp.ready);
   end

   // Sequence: take a glyph, fetch its font bits, emit its pixels
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start.draw) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cnt_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               cnt_in = cnt_ff + 1'b1;
               if (pix_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Glyph and pixel payload registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (state_ff == ST_IDLE && start.draw) begin
         idx_ff      <= start.glyph_idx;
         base_col_ff <= start.base_col;
         base_row_ff <= start.base_row;
      end
      if (state_ff == ST_FETCH) begin
         glyph_ff <= glyph_bits(idx_ff);
      end else if (load) begin
         glyph_ff <= glyph_ff >> 1;
      end
      if (load) begin
         out_row_ff   <= pix_row;
         out_col_ff   <= pix_x[6:0];
         out_color_ff <= glyph_ff[0] ? text_color : background_color;
         out_off_ff   <= pix_off;
         out_last_ff  <= pix_last;
      end
   end

   assign idle            = (state_ff == ST_IDLE);
   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel_row   = out_row_ff;
   assign rsp.pixel_col   = out_col_ff;
   assign rsp.pixel_color = out_color_ff;
   assign rsp.off_screen  = out_off_ff;
   assign rsp.last        = out_last_ff;

endmodule

>>> hdl/text_glyph_pixel_generator_unit.sv
// Top level of the 6x8 text glyph pixel generator.
//
//   channel  direction  carries                      handshake
//   req_if   in         char_code                    valid / ready
//   rsp_if   out        row, col, color, flags       valid / ready
//   csr_*    in         four registers by index      write enable only
//
// A printable code (32 to 127) is taken, the font table is read, then 48 pixel items
// follow, one per cycle unless rsp_if stalls, through a single pixel counter.
// Any other code updates the cursor in its accept cycle and gives no pixel items.
// The next item is taken while the last pixel still waits in the output register.
// A stall on rsp_if holds the pixel counter; reset is synchronous and clears the
// cursor, sequencer state, output valid and configuration registers to reset values.
module text_glyph_pixel_generator_unit
   import tgpg_pkg::*;
#(
   parameter int SCREEN_COLS = 96,
   parameter int SCREEN_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   tgpg_req_if.sink    req_if,
   tgpg_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] text_color_ff;
   logic [15:0] back_color_ff;
   logic [6:0]  left_margin_ff;
   logic [5:0]  top_margin_ff;
   logic        seq_idle;
   logic        accept;
   start_type   start;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff  <= 16'hFFFF;
         back_color_ff  <= '0;
         left_margin_ff <= '0;
         top_margin_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEXT_COLOR:  text_color_ff  <= csr_wdata;
            CSR_BACK_COLOR:  back_color_ff  <= csr_wdata;
            CSR_LEFT_MARGIN: left_margin_ff <= csr_wdata[6:0];
            CSR_TOP_MARGIN:  top_margin_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Take a new item only while the sequencer is free
   assign req_if.ready = seq_idle;
   assign accept       = req_if.valid && seq_idle;

   tgpg_cursor #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_cursor (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_if.char_code),
      .left_margin (left_margin_ff),
      .top_margin  (top_margin_ff),
      .start       (start)
   );

   tgpg_pixel_seq #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_pixel_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .text_color       (text_color_ff),
      .background_color (back_color_ff),
      .idle             (seq_idle),
      .rsp              (rsp_if)
   );

endmodule

>>> hdl/tgpg_checker.sv
// Port checker for the glyph pixel generator and its bind to the top level.
`include "assert_macros.svh"

module tgpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_row,
   input logic [6:0]  rsp_col,
   input logic [15:0] rsp_color,
   input logic        rsp_last
);

   // Hold a stalled pixel item unchanged
   `TGPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_color) && $stable(rsp_last), "stalled pixel item changed")

   // Take a character only when no glyph is part way out
   `TGPG_ASSERT(a_req_between_glyphs, clock, reset, !(req_valid && req_ready) || !rsp_valid || rsp_last, "character taken in the middle of a glyph")

   // Follow each non-final pixel of a glyph with the next one at once
   `TGPG_ASSERT_NEXT(a_rsp_no_gap, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "gap inside a glyph burst")

   // Keep the input closed while pixels of a glyph are still to come
   `TGPG_ASSERT(a_req_closed, clock, reset, !(rsp_valid && !rsp_last) || !req_ready, "input open during a glyph burst")

endmodule

bind text_glyph_pixel_generator_unit tgpg_checker u_tgpg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_row   (rsp_if.pixel_row),
   .rsp_col   (rsp_if.pixel_col),
   .rsp_color (rsp_if.pixel_color),
   .rsp_last  (rsp_if.last)
);
